@@ rtl/imhq_pkg.sv @@
// Shared types and constants for the indexed min-heap queue.
`timescale 1ns / 1ps
package imhq_pkg;

    localparam int KEY_W         = 10;
    localparam int PRI_W         = 32;
    localparam int COUNT_W       = 11;
    localparam int KEY_COUNT_DEF = 1024;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [KEY_W-1:0] key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_TOP,
        ST_POP_LAST,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_RC,
        ST_DN_DEC
    } state_t;

endpackage

@@ rtl/imhq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/indexed_min_heap_queue.sv @@
// Indexed binary min-heap with key-to-slot map; top level and sequencer.
// Push looks up the key's slot, then climbs one level per compare; pop reads the top and the last
// entry, then descends, reading the left and then the right child; heap RAM reads are serialized
// on the single heap RAM read port.
// One request is in flight at a time; the next waits until the result register is taken.
// After reset the slot map is cleared one key per cycle, with s_ready low.
`timescale 1ns / 1ps
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [KEY_W-1:0]   s_key,
    input  logic [PRI_W-1:0]   s_priority_req,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KEY_W-1:0]   m_popped_key,
    output logic [PRI_W-1:0]   m_popped_priority,
    output logic               m_empty_error,
    output logic [COUNT_W-1:0] m_entry_count
);

    localparam int SW  = $clog2(KEY_COUNT + 1);
    localparam int KAW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    state_t state_reg, state_next;

    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [SW-1:0]    p_reg, p_next;
    logic [SW-1:0]    c_reg, c_next;
    entry_t           cur_reg, cur_next;
    entry_t           child_reg, child_next;
    logic [KEY_W-1:0] res_key_reg, res_key_next;
    logic [PRI_W-1:0] res_pri_reg, res_pri_next;
    logic             err_reg, err_next;
    logic [KAW-1:0]   clr_reg, clr_next;

    logic               m_valid_reg;
    logic [KEY_W-1:0]   m_key_reg;
    logic [PRI_W-1:0]   m_pri_reg;
    logic               m_err_reg;
    logic [COUNT_W-1:0] m_cnt_reg;

    logic          h_we;
    logic [SW-1:0] h_waddr, h_raddr;
    entry_t        h_wdata, h_rdata;
    logic [ENTRY_W-1:0] h_rdata_raw;
    logic           s_we;
    logic [KAW-1:0] s_waddr, s_raddr;
    logic [SW-1:0]  s_wdata, s_rdata;

    logic          accept, key_ok, lk_present, up_go, dn_swap, rc_take;
    logic          has_left, has_right, fin, clr_last;
    logic [SW:0]   l_w, r_w, cnt_ext;

    imhq_ram #(.WIDTH(ENTRY_W), .DEPTH(KEY_COUNT + 1)) u_heap_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata_raw)
    );
    assign h_rdata = entry_t'(h_rdata_raw);

    imhq_ram #(.WIDTH(SW), .DEPTH(KEY_COUNT)) u_slot_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign s_ready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign key_ok     = 32'(s_key) < 32'(KEY_COUNT);
    assign lk_present = (s_rdata != '0) && (s_rdata <= cnt_reg);
    assign up_go      = h_rdata.pri > cur_reg.pri;
    assign dn_swap    = child_reg.pri < cur_reg.pri;
    assign rc_take    = h_rdata.pri < child_reg.pri;
    assign l_w        = {p_reg, 1'b0};
    assign r_w        = {p_reg, 1'b1};
    assign cnt_ext    = {1'b0, cnt_reg};
    assign has_left   = l_w <= cnt_ext;
    assign has_right  = r_w <= cnt_ext;
    assign clr_last   = clr_reg == KAW'(KEY_COUNT - 1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_POP) begin
                        if (cnt_reg != '0) state_next = ST_POP_TOP;
                    end else if (key_ok) begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                if (lk_present || (cnt_reg < SW'(KEY_COUNT))) state_next = ST_UP_RD;
                else state_next = ST_IDLE;
            end
            ST_UP_RD: begin
                state_next = (p_reg > SW'(1)) ? ST_UP_CMP : ST_IDLE;
            end
            ST_UP_CMP: begin
                state_next = up_go ? ST_UP_RD : ST_IDLE;
            end
            ST_POP_TOP: begin
                state_next = ST_POP_LAST;
            end
            ST_POP_LAST: begin
                state_next = (cnt_reg == SW'(1)) ? ST_IDLE : ST_DN_RDL;
            end
            ST_DN_RDL: begin
                state_next = has_left ? ST_DN_RDR : ST_IDLE;
            end
            ST_DN_RDR: begin
                state_next = has_right ? ST_DN_RC : ST_DN_DEC;
            end
            ST_DN_RC: begin
                state_next = ST_DN_DEC;
            end
            ST_DN_DEC: begin
                state_next = dn_swap ? ST_DN_RDL : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control. The moving entry stays in cur_reg and is
    // written once at its final slot; displaced entries shift into the hole.
    always_comb begin
        cnt_next     = cnt_reg;
        p_next       = p_reg;
        c_next       = c_reg;
        cur_next     = cur_reg;
        child_next   = child_reg;
        res_key_next = res_key_reg;
        res_pri_next = res_pri_reg;
        err_next     = err_reg;
        clr_next     = clr_reg;
        fin          = 1'b0;
        h_we         = 1'b0;
        h_waddr      = p_reg;
        h_wdata      = cur_reg;
        h_raddr      = '0;
        s_we         = 1'b0;
        s_waddr      = KAW'(cur_reg.key);
        s_wdata      = p_reg;
        s_raddr      = '0;
        case (state_reg)
            ST_CLEAR: begin
                s_we     = 1'b1;
                s_waddr  = clr_reg;
                s_wdata  = '0;
                clr_next = clr_reg + KAW'(1);
            end
            ST_IDLE: begin
                s_raddr = KAW'(s_key);
                h_raddr = SW'(1);
                if (accept) begin
                    cur_next     = '{pri: s_priority_req, key: s_key};
                    res_key_next = '0;
                    res_pri_next = '0;
                    err_next     = (s_kind == KIND_POP) && (cnt_reg == '0);
                    if (s_kind == KIND_POP) fin = cnt_reg == '0;
                    else fin = !key_ok;
                end
            end
            ST_LOOKUP: begin
                if (lk_present) begin
                    p_next = s_rdata;
                end else if (cnt_reg < SW'(KEY_COUNT)) begin
                    cnt_next = cnt_reg + SW'(1);
                    p_next   = cnt_reg + SW'(1);
                end else begin
                    fin = 1'b1;
                end
            end
            ST_UP_RD: begin
                if (p_reg > SW'(1)) begin
                    h_raddr = p_reg >> 1;
                end else begin
                    h_we = 1'b1;
                    s_we = 1'b1;
                    fin  = 1'b1;
                end
            end
            ST_UP_CMP: begin
                h_we = 1'b1;
                s_we = 1'b1;
                if (up_go) begin
                    h_wdata = h_rdata;
                    s_waddr = KAW'(h_rdata.key);
                    p_next  = p_reg >> 1;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_POP_TOP: begin
                res_key_next = h_rdata.key;
                res_pri_next = h_rdata.pri;
                h_raddr      = cnt_reg;
            end
            ST_POP_LAST: begin
                cur_next = h_rdata;
                s_we     = 1'b1;
                s_waddr  = KAW'(res_key_reg);
                s_wdata  = '0;
                cnt_next = cnt_reg - SW'(1);
                p_next   = SW'(1);
                fin      = cnt_reg == SW'(1);
            end
            ST_DN_RDL: begin
                if (has_left) begin
                    h_raddr = SW'(l_w);
                end else begin
                    h_we = 1'b1;
                    s_we = 1'b1;
                    fin  = 1'b1;
                end
            end
            ST_DN_RDR: begin
                child_next = h_rdata;
                c_next     = SW'(l_w);
                h_raddr    = SW'(r_w);
            end
            ST_DN_RC: begin
                if (rc_take) begin
                    child_next = h_rdata;
                    c_next     = SW'(r_w);
                end
            end
            ST_DN_DEC: begin
                h_we = 1'b1;
                s_we = 1'b1;
                if (dn_swap) begin
                    h_wdata = child_reg;
                    s_waddr = KAW'(child_reg.key);
                    p_next  = c_reg;
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            if (fin) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        c_reg       <= c_next;
        cur_reg     <= cur_next;
        child_reg   <= child_next;
        res_key_reg <= res_key_next;
        res_pri_reg <= res_pri_next;
        err_reg     <= err_next;
        if (fin) begin
            m_key_reg <= res_key_next;
            m_pri_reg <= res_pri_next;
            m_err_reg <= err_next;
            m_cnt_reg <= COUNT_W'(cnt_next);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_popped_key      = m_key_reg;
    assign m_popped_priority = m_pri_reg;
    assign m_empty_error     = m_err_reg;
    assign m_entry_count     = m_cnt_reg;

endmodule

@@ tb/heap_checker.sv @@
// Heap behavior predictor and result checker for the indexed min-heap queue.
`timescale 1ns / 1ps
module heap_checker
    import imhq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_kind,
    input  logic [KEY_W-1:0]   s_key,
    input  logic [PRI_W-1:0]   s_priority_req,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [KEY_W-1:0]   m_popped_key,
    input  logic [PRI_W-1:0]   m_popped_priority,
    input  logic               m_empty_error,
    input  logic [COUNT_W-1:0] m_entry_count,
    output int                 fail_count,
    output int                 pending_results,
    output int                 pop_count,
    output int                 empty_pops
);

    typedef struct packed {
        logic [KEY_W-1:0]   pkey;
        logic [PRI_W-1:0]   ppri;
        logic               err;
        logic [COUNT_W-1:0] count;
    } heap_result_t;

    entry_t             slots [1:KEY_COUNT_DEF];
    int unsigned        slot_map [KEY_COUNT_DEF];
    int unsigned        held;
    heap_result_t       expected_results [$];

    function automatic void swap_entries(input int unsigned a, input int unsigned b);
        entry_t t;
        t = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
        slot_map[slots[a].key] = a;
        slot_map[slots[b].key] = b;
    endfunction

    function automatic void bubble_up(input int unsigned p);
        while (p > 1 && slots[p/2].pri > slots[p].pri) begin
            swap_entries(p, p/2);
            p = p / 2;
        end
    endfunction

    function automatic void bubble_down(input int unsigned k);
        int unsigned l, s;
        while (k * 2 <= held) begin
            l = k * 2;
            s = (l + 1 <= held && slots[l+1].pri < slots[l].pri) ? l + 1 : l;
            if (slots[s].pri >= slots[k].pri) break;
            swap_entries(k, s);
            k = s;
        end
    endfunction

    function automatic heap_result_t apply_request(input logic kind, input logic [KEY_W-1:0] key,
                                                    input logic [PRI_W-1:0] pri);
        heap_result_t r;
        int unsigned s;
        logic [KEY_W-1:0] top;
        r = '0;
        if (kind == KIND_PUSH) begin
            s = slot_map[key];
            if (s >= 1 && s <= held) begin
                slots[s].pri = pri;
                bubble_up(s);
            end else if (held < KEY_COUNT_DEF) begin
                held++;
                slots[held].pri = pri;
                slots[held].key = key;
                slot_map[key] = held;
                bubble_up(held);
            end
        end else if (held == 0) begin
            r.err = 1'b1;
        end else begin
            top = slots[1].key;
            r.pkey = top;
            r.ppri = slots[1].pri;
            swap_entries(1, held);
            held--;
            bubble_down(1);
            slot_map[top] = 0;
        end
        r.count = COUNT_W'(held);
        return r;
    endfunction

    always @(posedge aclk) begin
        heap_result_t e;
        if (!aresetn) begin
            held = 0;
            foreach (slot_map[i]) slot_map[i] = 0;
            expected_results.delete();
            fail_count <= 0;
            pending_results <= 0;
            pop_count <= 0;
            empty_pops <= 0;
        end else begin
            if (s_valid && s_ready) begin
                e = apply_request(s_kind, s_key, s_priority_req);
                expected_results.insert(expected_results.size(), e);
                if (s_kind == KIND_POP) begin
                    if (e.err) empty_pops <= empty_pops + 1;
                    else pop_count <= pop_count + 1;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("ERROR: unexpected result at %0t", $time);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_popped_key !== e.pkey || m_popped_priority !== e.ppri ||
                        m_empty_error !== e.err || m_entry_count !== e.count) begin
                        if (fail_count < 10)
                            $display({"ERROR: exp key=%0d pri=%h err=%b cnt=%0d,",
                                      " got key=%0d pri=%h err=%b cnt=%0d"},
                                     e.pkey, e.ppri, e.err, e.count, m_popped_key,
                                     m_popped_priority, m_empty_error, m_entry_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top-level testbench: stimulus, flow control and verdict for the heap queue.
`timescale 1ns / 1ps
module testbench;
    import imhq_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = KIND_PUSH;
    logic [KEY_W-1:0]   s_key = '0;
    logic [PRI_W-1:0]   s_priority_req = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [KEY_W-1:0]   m_popped_key;
    logic [PRI_W-1:0]   m_popped_priority;
    logic               m_empty_error;
    logic [COUNT_W-1:0] m_entry_count;
    int                 fail_count, pending_results, pop_count, empty_pops;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 recv_hold = 0;
    logic               hold_tgl = 1'b0;
    logic               hold_seen = 1'b0;
    int                 requests_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    indexed_min_heap_queue u_top (.*);

    heap_checker u_checker (.*);

    // The receiver stalls at random, and for a long stretch each time hold_tgl flips.
    always @(posedge aclk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            m_ready <= 1'b0;
            recv_hold <= 400;
        end else if (recv_hold > 0) begin
            m_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request, holding it until accepted, with random gaps first.
    task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                                input logic [PRI_W-1:0] pri);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_key <= key;
        s_priority_req <= pri;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0 || s_valid) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [PRI_W-1:0] rand_priority();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFFF - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 45)
                send_request(KIND_POP, KEY_W'($urandom), $urandom);
            else if ($urandom_range(3) == 0)
                send_request(KIND_PUSH, KEY_W'($urandom_range(15)), rand_priority());
            else
                send_request(KIND_PUSH, KEY_W'($urandom), rand_priority());
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pop, extreme keys and priorities, ties, re-prioritizing.
        send_request(KIND_POP, 10'h3FF, 32'hFFFF_FFFF);
        send_request(KIND_PUSH, 10'd0, 32'hFFFF_FFFF);
        send_request(KIND_PUSH, 10'h3FF, 32'd0);
        send_request(KIND_PUSH, 10'd5, 32'd100);
        send_request(KIND_PUSH, 10'd6, 32'd100);
        send_request(KIND_PUSH, 10'd7, 32'd100);
        send_request(KIND_PUSH, 10'd0, 32'd1);
        send_request(KIND_PUSH, 10'd5, 32'h8000_0000);
        send_request(KIND_PUSH, 10'h2AA, 32'hAAAA_AAAA);
        send_request(KIND_PUSH, 10'h155, 32'h5555_5555);
        for (int i = 0; i < 9; i++) send_request(KIND_POP, '0, '0);
        send_request(KIND_PUSH, 10'd9, 32'd3);
        send_request(KIND_POP, '0, '0);

        // The receiver holds off while requests keep coming, so the input backs up.
        hold_tgl <= ~hold_tgl;
        random_phase(20);
        // Pause the sender until everything has drained.
        wait_drained();

        send_idle_pct = 26; recv_idle_pct = 57;
        random_phase(160);
        send_idle_pct = 57; recv_idle_pct = 26;
        random_phase(160);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(140);
        wait_drained();

        $display("Ran %0d requests: %0d pops returned a key, %0d pops hit an empty heap.",
                 requests_sent, pop_count, empty_pops);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/imhq_pkg.sv
rtl/imhq_ram.sv
rtl/indexed_min_heap_queue.sv
tb/heap_checker.sv
tb/testbench.sv
